>>> design/assert_macros.svh
// Assertion helpers, included by the matcher top level.
// Each use samples on the rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every sampled edge.
`define MPSM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// A trigger that must be followed by a consequence in the next cycle.
`define MPSM_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

>>> design/mpsm_pkg.sv
`timescale 1ns / 1ps

package mpsm_pkg;

   localparam int unsigned WindowLen   = 64;
   localparam int unsigned NumPatterns = 20;
   localparam int unsigned TableSize   = 20;
   localparam int unsigned ActivePatterns =
      (NumPatterns < TableSize) ? NumPatterns : TableSize;

   // Each fragment is stored right-justified: its last character sits in bits [7:0].
   localparam int unsigned PatBytes = 48;

   typedef logic [15:0]               char_type;
   typedef logic [ActivePatterns-1:0] match_type;

   localparam logic [PatBytes*8-1:0] Patterns [TableSize] = '{
      "\\CurrentVersion\\Run",
      "\\CurrentVersion\\RunOnce",
      "\\CurrentVersion\\RunOnceEx",
      "\\CurrentVersion\\RunServices",
      "\\CurrentVersion\\RunServicesOnce",
      "\\CurrentVersion\\Explorer\\StartupApproved",
      "\\CurrentControlSet\\Services",
      "\\Schedule\\TaskCache",
      "\\CurrentVersion\\Winlogon",
      "\\CurrentVersion\\Image File Execution Options",
      "\\CurrentVersion\\Windows",
      "\\CurrentVersion\\ShellServiceObjectDelayLoad",
      "\\Classes\\CLSID",
      "\\Session Manager",
      "\\CurrentVersion\\WMI\\Autologger",
      "\\CurrentControlSet\\Control\\Lsa",
      "\\CurrentControlSet\\Control\\SecurityProviders",
      "\\CurrentControlSet\\Control\\Print\\Monitors",
      "\\CurrentControlSet\\Services\\WinSock2",
      "\\Explorer\\Browser Helper Objects"
   };

   function automatic char_type fold_char(input char_type c);
      char_type r;
      r = c;
      if (c inside {[16'h0061:16'h007A]}) begin
         r = c - 16'h0020;
      end
      return r;
   endfunction

   function automatic int unsigned pat_len(input int unsigned p);
      int unsigned n;
      n = 0;
      for (int unsigned b = 0; b < PatBytes; b++) begin
         if (Patterns[p][8*b +: 8] != 8'h00) begin
            n = b + 1;
         end
      end
      return n;
   endfunction

   function automatic int unsigned max_pat_len();
      int unsigned m;
      m = 1;
      for (int unsigned p = 0; p < ActivePatterns; p++) begin
         if (pat_len(p) > m) begin
            m = pat_len(p);
         end
      end
      return m;
   endfunction

   // A fragment can only hit when it fits in the window.
   function automatic logic pat_usable(input int unsigned p);
      return (pat_len(p) > 0) && (pat_len(p) <= WindowLen);
   endfunction

   // Character j of fragment p, counted from its start, folded to upper case.
   function automatic char_type pat_char(input int unsigned p, input int unsigned j);
      int unsigned len;
      char_type    c;
      len = pat_len(p);
      c   = '0;
      if (j < len) begin
         c = fold_char({8'h00, Patterns[p][8*(len-1-j) +: 8]});
      end
      return c;
   endfunction

   localparam int unsigned CellCount =
      (max_pat_len() < WindowLen) ? max_pat_len() : WindowLen;

endpackage

>>> design/mpsm_ifs.sv
`timescale 1ns / 1ps

interface mpsm_req_if;
   logic                valid;
   logic                ready;
   mpsm_pkg::char_type  key_char;
   logic                last_char;

   modport source (output valid, output key_char, output last_char, input ready);
   modport sink   (input valid, input key_char, input last_char, output ready);
endinterface

interface mpsm_rsp_if;
   logic valid;
   logic ready;
   logic is_persistence;

   modport source (output valid, output is_persistence, input ready);
   modport sink   (input valid, input is_persistence, output ready);
endinterface

>>> design/multi_pattern_substring_matcher.sv
`timescale 1ns / 1ps
// The result for a path is on rsp_ch in the cycle after its last character is accepted.
// Throughput: one character per cycle; the fragment chain compares every position at once.
// Apart from reset, the request side stalls only while a finished result waits on a stalled response side.
// Reset (synchronous, active high) clears the chain, the hit flag and the output register;
// no character is accepted while reset is high.
`include "assert_macros.svh"

module multi_pattern_substring_matcher (
   input  logic     clock,
   input  logic     reset,
   mpsm_req_if.sink   req_ch,
   mpsm_rsp_if.source rsp_ch
);

   localparam int unsigned Cells = mpsm_pkg::CellCount;

   mpsm_pkg::char_type  folded;
   logic                accept;
   logic                clear;
   mpsm_pkg::match_type cell_next [Cells];
   mpsm_pkg::match_type cell_out  [Cells];
   logic                any_hit;

   logic hit_seen_ff;
   logic hit_seen_in;
   logic out_valid_ff;
   logic out_valid_in;
   logic out_data_ff;
   logic out_data_in;

   assign req_ch.ready = !reset && (!out_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;
   assign clear        = accept && req_ch.last_char;
   assign folded       = mpsm_pkg::fold_char(req_ch.key_char);

   for (genvar j = 0; j < Cells; j++) begin : g_cell
      mpsm_pkg::char_type  col_char [mpsm_pkg::ActivePatterns];
      mpsm_pkg::match_type col_valid;
      mpsm_pkg::match_type link;

      always_comb begin
         for (int p = 0; p < mpsm_pkg::ActivePatterns; p++) begin
            col_char[p]  = mpsm_pkg::pat_char(p, j);
            col_valid[p] = mpsm_pkg::pat_usable(p) && (j < mpsm_pkg::pat_len(p));
         end
      end

      // The first position starts a new attempt at every character.
      if (j == 0) begin : g_head
         assign link = '1;
      end else begin : g_body
         assign link = cell_out[j-1];
      end

      mpsm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (accept),
         .clear      (clear),
         .char_in    (folded),
         .col_char   (col_char),
         .col_valid  (col_valid),
         .match_in   (link),
         .match_next (cell_next[j]),
         .match_out  (cell_out[j])
      );
   end

   // A fragment hits when its full length lines up at the newest character.
   always_comb begin
      any_hit = 1'b0;
      for (int p = 0; p < mpsm_pkg::ActivePatterns; p++) begin
         if (mpsm_pkg::pat_usable(p)) begin
            any_hit = any_hit | cell_next[mpsm_pkg::pat_len(p) - 1][p];
         end
      end
   end

   always_comb begin
      hit_seen_in  = hit_seen_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_valid_ff && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
      if (accept) begin
         if (req_ch.last_char) begin
            hit_seen_in  = 1'b0;
            out_valid_in = 1'b1;
            out_data_in  = hit_seen_ff | any_hit;
         end else begin
            hit_seen_in = hit_seen_ff | any_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_seen_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         out_data_ff  <= 1'b0;
      end else begin
         hit_seen_ff  <= hit_seen_in;
         out_valid_ff <= out_valid_in;
         out_data_ff  <= out_data_in;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.is_persistence = out_data_ff;

   `MPSM_ASSERT_NEXT(a_last_gives_result, clear, out_valid_ff, "last item produced no result")
   `MPSM_ASSERT_NEXT(a_last_clears_state, clear, !hit_seen_ff && (cell_out[0] == '0),
                     "state not cleared after last item")
   `MPSM_ASSERT(a_result_needs_last, $rose(out_valid_ff) |-> $past(clear),
                "result appeared without a last item")

endmodule

>>> design/mpsm_cell.sv
`timescale 1ns / 1ps

// One position of the fragment chain. Bit p of the state says that the first
// (position + 1) characters of fragment p end at the newest character.
module mpsm_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                clear,
   input  mpsm_pkg::char_type  char_in,
   input  mpsm_pkg::char_type  col_char [mpsm_pkg::ActivePatterns],
   input  mpsm_pkg::match_type col_valid,
   input  mpsm_pkg::match_type match_in,
   output mpsm_pkg::match_type match_next,
   output mpsm_pkg::match_type match_out
);

   mpsm_pkg::match_type match_ff;
   mpsm_pkg::match_type match_upd_in;
   mpsm_pkg::match_type equal_vec;

   always_comb begin
      for (int p = 0; p < mpsm_pkg::ActivePatterns; p++) begin
         equal_vec[p] = (char_in == col_char[p]);
      end
   end

   assign match_next = match_in & col_valid & equal_vec;

   always_comb begin
      match_upd_in = match_ff;
      if (clear) begin
         match_upd_in = '0;
      end else if (advance) begin
         match_upd_in = match_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= '0;
      end else begin
         match_ff <= match_upd_in;
      end
   end

   assign match_out = match_ff;

endmodule
